/* design/gost94_pkg.sv */
`default_nettype none
package gost94_pkg;

    typedef logic [7:0][63:0] sbox_t;

    localparam logic [255:0] C3 = {64'hff00ffff000000ff, 64'hff0000ff00ffff00,
                                   64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00};

    localparam int unsigned PSI_MSG_STEP   = 12;
    localparam int unsigned PSI_CHAIN_STEP = 13;
    localparam int unsigned PSI_LAST_STEP  = 73;

    // 32-bit round function: add key, eight 4-bit S-boxes, rotate left by 11
    function automatic logic [31:0] round_fn(logic [31:0] x, logic [31:0] k, sbox_t sb);
        logic [31:0] s;
        logic [31:0] o;
        s = x + k;
        o = '0;
        for (int i = 0; i < 8; i++)
        begin
            o[4*i +: 4] = sb[i][{s[4*i +: 4], 2'b00} +: 4];
        end
        return {o[20:0], o[31:21]};
    endfunction

    // key byte j comes from byte 8*(j mod 4) + j/4
    function automatic logic [255:0] shuffle(logic [255:0] y);
        logic [255:0] r;
        logic [4:0]   jj;
        logic [4:0]   src;
        r = '0;
        for (int j = 0; j < 32; j++)
        begin
            jj  = 5'(j);
            src = {jj[1:0], jj[4:2]};
            r[8*j +: 8] = y[{src, 3'b000} +: 8];
        end
        return r;
    endfunction

    function automatic logic [255:0] a_map(logic [255:0] y);
        return {y[63:0] ^ y[127:64], y[255:64]};
    endfunction

    function automatic logic [255:0] psi_once(logic [255:0] v);
        logic [15:0] x;
        x = v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48] ^ v[207:192] ^ v[255:240];
        return {x, v[255:16]};
    endfunction

endpackage
`default_nettype wire

/* design/gost94_step.sv */
`default_nettype none
module gost94_step
    import gost94_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire sbox_t        sbox,
    input  wire logic [255:0] chain_in,
    input  wire logic [255:0] msg_in,
    output logic              done,
    output logic [255:0]      result
);

    typedef enum logic [1:0] {ST_IDLE, ST_KEYGEN, ST_CIPHER, ST_PSI} state_t;

    state_t              state_reg;
    logic [255:0]        u_reg;
    logic [255:0]        v_reg;
    logic [255:0]        chain_reg;
    logic [255:0]        msg_reg;
    logic [3:0][255:0]   key_reg;
    logic [31:0]         a_reg;
    logic [31:0]         b_reg;
    logic [1:0]          j_reg;
    logic [4:0]          round_reg;
    logic [1:0]          widx_reg;
    logic [6:0]          psi_reg;
    logic [255:0]        s_reg;
    logic                done_reg;

    logic [255:0] u_adv;
    logic [255:0] v_adv;
    logic [255:0] cur_key;
    logic [2:0]   kn;
    logic [31:0]  sk;
    logic [31:0]  t;
    logic [1:0]   widx_inc;
    logic [255:0] psi_in;

    always_comb
    begin
        u_adv    = a_map(u_reg) ^ ((j_reg == 2'd2) ? C3 : 256'd0);
        v_adv    = a_map(a_map(v_reg));
        cur_key  = key_reg[widx_reg];
        // subkeys run 0..7 three times, then 7..0
        kn       = (round_reg < 5'd24) ? round_reg[2:0] : ~round_reg[2:0];
        sk       = cur_key[{kn, 5'b00000} +: 32];
        t        = round_fn(a_reg, sk, sbox) ^ b_reg;
        widx_inc = widx_reg + 2'd1;
        psi_in   = s_reg
                 ^ ((psi_reg == 7'(PSI_MSG_STEP))   ? msg_reg   : 256'd0)
                 ^ ((psi_reg == 7'(PSI_CHAIN_STEP)) ? chain_reg : 256'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            j_reg     <= '0;
            round_reg <= '0;
            widx_reg  <= '0;
            psi_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        u_reg     <= chain_in;
                        v_reg     <= msg_in;
                        chain_reg <= chain_in;
                        msg_reg   <= msg_in;
                        j_reg     <= '0;
                        state_reg <= ST_KEYGEN;
                    end
                end
                ST_KEYGEN:
                begin
                    if (j_reg == 2'd0)
                    begin
                        key_reg[0] <= shuffle(u_reg ^ v_reg);
                    end
                    else
                    begin
                        key_reg[j_reg] <= shuffle(u_adv ^ v_adv);
                        u_reg          <= u_adv;
                        v_reg          <= v_adv;
                    end
                    j_reg <= j_reg + 2'd1;
                    if (j_reg == 2'd3)
                    begin
                        widx_reg  <= '0;
                        round_reg <= '0;
                        a_reg     <= chain_reg[31:0];
                        b_reg     <= chain_reg[63:32];
                        state_reg <= ST_CIPHER;
                    end
                end
                ST_CIPHER:
                begin
                    a_reg     <= t;
                    b_reg     <= a_reg;
                    round_reg <= round_reg + 5'd1;
                    if (round_reg == 5'd31)
                    begin
                        s_reg[{widx_reg, 6'b000000} +: 64] <= {t, a_reg};
                        if (widx_reg == 2'd3)
                        begin
                            psi_reg   <= '0;
                            state_reg <= ST_PSI;
                        end
                        else
                        begin
                            widx_reg <= widx_inc;
                            a_reg    <= chain_reg[{widx_inc, 6'b000000} +: 32];
                            b_reg    <= chain_reg[{widx_inc, 6'b100000} +: 32];
                        end
                    end
                end
                ST_PSI:
                begin
                    // 12 shifts, mix message, 1 shift, mix chain, 61 shifts
                    s_reg   <= psi_once(psi_in);
                    psi_reg <= psi_reg + 7'd1;
                    if (psi_reg == 7'(PSI_LAST_STEP))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = s_reg;

    a_done_after_psi: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_PSI && state_reg == ST_IDLE))
        else $error("step done without psi phase");

    a_cipher_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CIPHER && round_reg == 5'd31 && widx_reg == 2'd3)
            |=> (state_reg == ST_PSI && psi_reg == 7'd0))
        else $error("cipher did not hand over to psi");

    a_keygen_len: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_CIPHER) |-> ($past(j_reg) == 2'd3))
        else $error("cipher started before four keys");

endmodule
`default_nettype wire

/* design/gost_94_hash_core.sv */
`default_nettype none
// GOST R 34.11-94 hash core (256-bit digest, zero start vector). Send the message as
// 64-bit requests, first byte in bits 7:0; every request but the final one carries 8 bytes.
// Each 32-byte block costs a 64-bit word-by-word block-sum addition and one compression
// (4 key-generation steps, 128 cipher rounds through a single shared round unit, 74 psi
// shifts): a chunk that fills a block holds in_stall high through both, the other
// chunks raise no stall. The final request adds the padded tail block (if any), then the
// length and sum compressions, then four digest words, low bytes first, digest_last on the
// fourth. S-box rows are written through cfg_wr_en/cfg_index/cfg_data; the user must write
// them only while no message is in progress, as the block itself does not enforce this.
module gost_94_hash_core
    import gost94_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] data_bytes,
    input  wire logic [3:0]  byte_count,
    input  wire logic        final_chunk,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      digest_word,
    output logic             digest_last
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SUMADD, ST_WAIT_BLK, ST_WAIT_LEN, ST_WAIT_SUM, ST_OUT
    } state_t;

    state_t           state_reg;
    sbox_t            sbox_reg;
    logic [3:0][63:0] chain_reg;
    logic [3:0][63:0] sum_reg;
    logic [3:0][63:0] buf_reg;
    logic [63:0]      len_reg;
    logic [1:0]       ptr_reg;
    logic [1:0]       cnt_reg;
    logic             carry_reg;
    logic             fin_reg;
    logic             start_reg;

    logic         in_fire;
    logic         out_fire;
    logic [3:0]   count_eff;
    logic [63:0]  masked;
    logic [64:0]  add_sum;
    logic [255:0] msg_sel;
    logic         step_done;
    logic [255:0] step_result;

    always_comb
    begin
        in_fire   = in_valid && !in_stall;
        out_fire  = out_valid && !out_stall;
        count_eff = (final_chunk && byte_count <= 4'd8) ? byte_count : 4'd8;
        for (int b = 0; b < 8; b++)
        begin
            masked[8*b +: 8] = (4'(b) < count_eff) ? data_bytes[8*b +: 8] : 8'h00;
        end
        add_sum = {1'b0, sum_reg[cnt_reg]} + {1'b0, buf_reg[cnt_reg]} + {64'd0, carry_reg};
        case (state_reg)
            ST_WAIT_BLK: msg_sel = buf_reg;
            ST_WAIT_LEN: msg_sel = {192'd0, len_reg};
            default:     msg_sel = sum_reg;
        endcase
    end

    gost94_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .sbox     (sbox_reg),
        .chain_in (chain_reg),
        .msg_in   (msg_sel),
        .done     (step_done),
        .result   (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbox_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            sbox_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chain_reg <= '0;
            sum_reg   <= '0;
            buf_reg   <= '0;
            len_reg   <= '0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            carry_reg <= 1'b0;
            fin_reg   <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        buf_reg[ptr_reg] <= masked;
                        len_reg          <= len_reg + {57'd0, count_eff, 3'b000};
                        cnt_reg          <= '0;
                        carry_reg        <= 1'b0;
                        if (!final_chunk)
                        begin
                            fin_reg <= 1'b0;
                            ptr_reg <= ptr_reg + 2'd1;
                            if (ptr_reg == 2'd3)
                            begin
                                state_reg <= ST_SUMADD;
                            end
                        end
                        else
                        begin
                            fin_reg <= 1'b1;
                            ptr_reg <= '0;
                            if (ptr_reg != 2'd0 || count_eff != 4'd0)
                            begin
                                state_reg <= ST_SUMADD;
                            end
                            else
                            begin
                                start_reg <= 1'b1;
                                state_reg <= ST_WAIT_LEN;
                            end
                        end
                    end
                end
                ST_SUMADD:
                begin
                    sum_reg[cnt_reg] <= add_sum[63:0];
                    carry_reg        <= add_sum[64];
                    cnt_reg          <= cnt_reg + 2'd1;
                    if (cnt_reg == 2'd3)
                    begin
                        start_reg <= 1'b1;
                        state_reg <= ST_WAIT_BLK;
                    end
                end
                ST_WAIT_BLK:
                begin
                    if (step_done)
                    begin
                        chain_reg <= step_result;
                        buf_reg   <= '0;
                        if (fin_reg)
                        begin
                            start_reg <= 1'b1;
                            state_reg <= ST_WAIT_LEN;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_WAIT_LEN:
                begin
                    if (step_done)
                    begin
                        chain_reg <= step_result;
                        start_reg <= 1'b1;
                        state_reg <= ST_WAIT_SUM;
                    end
                end
                ST_WAIT_SUM:
                begin
                    if (step_done)
                    begin
                        chain_reg <= step_result;
                        cnt_reg   <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_fire)
                    begin
                        cnt_reg <= cnt_reg + 2'd1;
                        if (cnt_reg == 2'd3)
                        begin
                            chain_reg <= '0;
                            sum_reg   <= '0;
                            buf_reg   <= '0;
                            len_reg   <= '0;
                            ptr_reg   <= '0;
                            fin_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = chain_reg[cnt_reg];
    assign digest_last = (cnt_reg == 2'd3);

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        step_done |-> (state_reg == ST_WAIT_BLK || state_reg == ST_WAIT_LEN
                       || state_reg == ST_WAIT_SUM))
        else $error("compression finished with nobody waiting");

    a_clear_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && digest_last) |=> (!out_valid && chain_reg == '0 && len_reg == '0))
        else $error("state not cleared after last digest word");

    a_out_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(step_done) && $past(state_reg) == ST_WAIT_SUM))
        else $error("digest shown before sum compression");

endmodule
`default_nettype wire

/* bench/gost_94_hash_core_tb.sv */
`timescale 1ns / 1ps
module gost_94_hash_core_tb;
    import gost94_pkg::*;

    localparam logic [2:0] SBOX_ROW_0 = 3'd0;
    localparam int N_SBOX_ROWS = 8;
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_ITEMS = 224;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        final_chunk;
    logic        out_valid;
    logic        out_stall;
    logic [63:0] digest_word;
    logic        digest_last;

    gost_94_hash_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_bytes(data_bytes), .byte_count(byte_count), .final_chunk(final_chunk),
        .out_valid(out_valid), .out_stall(out_stall),
        .digest_word(digest_word), .digest_last(digest_last)
    );

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } digest_t;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
        logic        fin;
        logic        has_known;
        logic [63:0] known_w0;
    } chunk_row_t;

    // predictor state
    logic [63:0]  sboxes [8];
    logic [255:0] hash_chain;
    logic [255:0] hash_sum;
    logic [63:0]  msg_bits;
    logic [255:0] pend_block;
    int unsigned  pend_fill;

    digest_t     digest_q[$];
    logic [63:0] known_q[$];
    int          errors;
    logic        hold_off;

    always #5 clk = ~clk;

    initial
    begin
        #80_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] feistel_f(logic [31:0] x, logic [31:0] k);
        logic [31:0] s;
        logic [31:0] o;
        logic [3:0]  nib;
        s = x + k;
        for (int i = 0; i < 8; i++)
        begin
            nib = s[4*i +: 4];
            o[4*i +: 4] = sboxes[i][4*nib +: 4];
        end
        return (o << 11) | (o >> 21);
    endfunction

    function automatic logic [63:0] encrypt_word(logic [63:0] d, logic [255:0] key);
        logic [31:0] a, b, t, sk;
        int n;
        a = d[31:0];
        b = d[63:32];
        for (int r = 0; r < 32; r++)
        begin
            n = (r < 24) ? (r % 8) : (7 - (r % 8));
            sk = key[32*n +: 32];
            t = feistel_f(a, sk) ^ b;
            b = a;
            a = t;
        end
        return {a, b};
    endfunction

    function automatic logic [255:0] key_perm(logic [255:0] y);
        logic [255:0] r;
        int src;
        for (int j = 0; j < 32; j++)
        begin
            src = ((j % 4) * 8) + (j / 4);
            r[8*j +: 8] = y[8*src +: 8];
        end
        return r;
    endfunction

    function automatic logic [255:0] rot_a(logic [255:0] y);
        return {y[63:0] ^ y[127:64], y[255:64]};
    endfunction

    function automatic logic [255:0] mix_psi(logic [255:0] v, int n);
        logic [15:0] x;
        for (int i = 0; i < n; i++)
        begin
            x = v[15:0] ^ v[31:16] ^ v[47:32] ^ v[63:48] ^ v[207:192] ^ v[255:240];
            v = {x, v[255:16]};
        end
        return v;
    endfunction

    task automatic step_hash(input logic [255:0] m);
        logic [255:0] u, v, s;
        logic [255:0] keys [4];
        logic [255:0] c3;
        c3 = {64'hff00ffff000000ff, 64'hff0000ff00ffff00,
              64'h00ff00ff00ff00ff, 64'hff00ff00ff00ff00};
        u = hash_chain;
        v = m;
        keys[0] = key_perm(u ^ v);
        for (int j = 1; j < 4; j++)
        begin
            u = rot_a(u);
            if (j == 2)
                u = u ^ c3;
            v = rot_a(rot_a(v));
            keys[j] = key_perm(u ^ v);
        end
        for (int i = 0; i < 4; i++)
            s[64*i +: 64] = encrypt_word(hash_chain[64*i +: 64], keys[i]);
        s = mix_psi(s, 12) ^ m;
        s = mix_psi(s, 1) ^ hash_chain;
        hash_chain = mix_psi(s, 61);
    endtask

    task automatic absorb_block();
        hash_sum = hash_sum + pend_block;
        step_hash(pend_block);
        pend_block = '0;
        pend_fill = 0;
    endtask

    task automatic clear_hash();
        hash_chain = '0;
        hash_sum = '0;
        msg_bits = '0;
        pend_block = '0;
        pend_fill = 0;
    endtask

    task automatic predict_chunk(input logic [63:0] d, input logic [3:0] cnt, input logic fin);
        int unsigned n;
        digest_t e;
        n = (!fin || cnt > 8) ? 8 : cnt;
        for (int b = 0; b < n; b++)
        begin
            pend_block[8*pend_fill +: 8] = d[8*b +: 8];
            pend_fill++;
            if (pend_fill == 32)
                absorb_block();
        end
        msg_bits = msg_bits + 64'(n * 8);
        if (fin)
        begin
            if (pend_fill > 0)
                absorb_block();
            step_hash({192'b0, msg_bits});
            step_hash(hash_sum);
            for (int k = 0; k < 4; k++)
            begin
                e.word = hash_chain[64*k +: 64];
                e.last = (k == 3);
                digest_q.push_back(e);
            end
            clear_hash();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    // result checker
    always @(posedge clk)
    begin
        digest_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
                report_mismatch("unexpected digest word", digest_word, 64'h0);
            else
            begin
                e = digest_q.pop_front();
                if (digest_word !== e.word)
                    report_mismatch("digest_word", digest_word, e.word);
                if (digest_last !== e.last)
                    report_mismatch("digest_last", {63'b0, digest_last}, {63'b0, e.last});
                if (known_q.size() > 0 && digest_q.size() % 4 == 3)
                begin
                    e.word = known_q.pop_front();
                    if (e.word !== 64'hx && digest_word !== e.word)
                        report_mismatch("known digest", digest_word, e.word);
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        int mode;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else
            begin
                mode = $urandom_range(0, 3);
                out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
            end
        end
    end

    task automatic write_sbox(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sboxes[idx] = val;
        @(posedge clk);
    endtask

    task automatic load_sboxes(input int style);
        for (int i = 0; i < N_SBOX_ROWS; i++)
        begin
            case (style)
                0: write_sbox(SBOX_ROW_0 + 3'(i), 64'h0);
                1: write_sbox(SBOX_ROW_0 + 3'(i), 64'hFFFF_FFFF_FFFF_FFFF);
                2: write_sbox(SBOX_ROW_0 + 3'(i), 64'hFEDC_BA98_7654_3210);
                default: write_sbox(SBOX_ROW_0 + 3'(i), {$urandom, $urandom});
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    // sender: offer one chunk, wait for acceptance
    task automatic send_chunk(input logic [63:0] d, input logic [3:0] cnt, input logic fin);
        in_valid    <= 1'b1;
        data_bytes  <= d;
        byte_count  <= cnt;
        final_chunk <= fin;
        predict_chunk(d, cnt, fin);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (digest_q.size() > 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        if (digest_q.size() > 0)
            report_mismatch("missing digest words", 64'(digest_q.size()), 64'h0);
        // tail compressions on chunks that give no digest
        repeat (1000) @(posedge clk);
    endtask

    task automatic random_message(input int nchunks);
        logic [3:0] cnt;
        logic [63:0] d;
        for (int c = 0; c < nchunks; c++)
        begin
            d = {$urandom, $urandom};
            cnt = 4'($urandom_range(0, 15));
            if (c == nchunks - 1)
                cnt = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 8));
            send_chunk(d, cnt, c == nchunks - 1);
            idle_gap();
        end
    endtask

    chunk_row_t rows [DIRECTED_ROWS];

    initial
    begin
        int sent;
        int len;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_bytes = '0;
        byte_count = '0;
        final_chunk = 1'b0;
        hold_off = 1'b0;
        errors = 0;
        foreach (sboxes[i]) sboxes[i] = '0;
        clear_hash();

        // data, count, final, known check
        rows[0]  = '{64'h0, 4'd0, 1'b1, 1'b0, 64'h0};                // empty message
        rows[1]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 64'h0};
        rows[2]  = '{64'h0123_4567_89AB_CDEF, 4'd15, 1'b1, 1'b0, 64'h0}; // oversized count
        rows[3]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 1'b0, 64'h0};  // bytes past count
        rows[4]  = '{64'hAAAA_AAAA_AAAA_AAAA, 4'd0, 1'b0, 1'b0, 64'h0};  // count ignored
        rows[5]  = '{64'h5555_5555_5555_5555, 4'd3, 1'b0, 1'b0, 64'h0};
        rows[6]  = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 1'b0, 64'h0};
        rows[7]  = '{64'h8000_0000_0000_0001, 4'd8, 1'b0, 1'b0, 64'h0};  // fills a block
        rows[8]  = '{64'h0, 4'd0, 1'b1, 1'b0, 64'h0};                    // empty tail
        for (int i = 9; i < DIRECTED_ROWS - 1; i++)
            rows[i] = '{64'h0101_0101_0101_0101 * 64'(i), 4'd8, 1'b0, 1'b0, 64'h0};
        rows[DIRECTED_ROWS-1] = '{64'hFEDC_BA98_7654_3210, 4'd7, 1'b1, 1'b0, 64'h0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero S-boxes first (reset state), then identity-like, all-ones, random
        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase > 0)
            begin
                drain();
                load_sboxes(phase == 1 ? 2 : phase == 2 ? 1 : 3);
            end
            foreach (rows[r])
            begin
                send_chunk(rows[r].data, rows[r].count, rows[r].fin);
                idle_gap();
            end
        end

        // pressure: receiver held off while messages keep coming
        drain();
        load_sboxes(3);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int m = 0; m < 4; m++)
                    random_message(2);
            end
        join

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent > 0 && $urandom_range(0, 9) == 0)
            begin
                drain();
                load_sboxes($urandom_range(0, 3) == 0 ? $urandom_range(0, 2) : 3);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
            random_message(len);
            sent += len;
        end

        drain();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
